// ----- design/segfmt_pkg.sv -----
// shared types, codes and glyph table of the segment display formatter
package segfmt_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int PEEL_STAGES = 7;

  localparam logic [23:0] DEC_MAX    = 24'd9999;
  localparam logic [23:0] HEX_MAX    = 24'h00FFFF;
  localparam logic [23:0] NIBBLE_MAX = 24'd15;
  localparam logic [23:0] FIX_MAX    = 24'd9999000;
  localparam logic [23:0] FIX_INT    = 24'd1000000;
  localparam logic [23:0] FIX_TENTHS = 24'd100000;
  localparam logic [23:0] FIX_HUNDS  = 24'd10000;

  localparam logic [23:0] POW10 [PEEL_STAGES] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000
  };

  localparam logic [7:0] SEG_E = 8'h79;
  localparam logic [7:0] SEG_R = 8'h44;

  typedef enum logic [3:0] {
    ACT_SET    = 4'd0,
    ACT_BLANK  = 4'd1,
    ACT_DEC    = 4'd2,
    ACT_HEX    = 4'd3,
    ACT_BIN    = 4'd4,
    ACT_FIXED  = 4'd5,
    ACT_PT_ON  = 4'd6,
    ACT_PT_OFF = 4'd7,
    ACT_ERROR  = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    FAULT_NONE  = 3'd0,
    FAULT_GLYPH = 3'd1,
    FAULT_POS   = 3'd2,
    FAULT_OVF   = 3'd3,
    FAULT_REQ   = 3'd4
  } fault_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [23:0] operand_value;
    logic [2:0]  position;
  } req_t;

  typedef struct packed {
    logic [7:0] digit_one;
    logic [7:0] digit_two;
    logic [7:0] digit_three;
    logic [7:0] digit_four;
    logic [2:0] fault;
  } res_t;

  typedef struct packed {
    logic [3:0]       mask;
    logic [3:0][7:0]  bytes;
    logic             pt_set;
    logic             pt_clr;
    logic [1:0]       idx;
    fault_t           fault;
  } cmd_t;

  typedef struct packed {
    req_t                        req;
    logic [PEEL_STAGES-1:0][3:0] dec;
    logic [23:0]                 rem;
  } front_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [23:0] rem;
  } peel_t;

  function automatic logic [7:0] glyph(input logic [3:0] n);
    logic [7:0] g;
    unique case (n)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      4'hF: g = 8'h71;
    endcase
    return g;
  endfunction

endpackage

// ----- design/segfmt_queue.sv -----
// small register queue between pipeline parts
module segfmt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = segfmt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == LIMIT);
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule

// ----- design/segfmt_front.sv -----
// front part: takes words, peels decimal digits and builds display commands
module segfmt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  segfmt_pkg::req_t  request,
  output logic              full,
  output logic              cmd_wr,
  output segfmt_pkg::cmd_t  cmd,
  input  logic              cmd_full
);

  localparam int NS = segfmt_pkg::PEEL_STAGES;

  segfmt_pkg::front_t st  [NS+1];
  segfmt_pkg::front_t nxt [1:NS];
  logic [NS:0]        vld;
  logic               adv;

  function automatic segfmt_pkg::peel_t peel(input logic [23:0] rem,
                                             input logic [23:0] pow);
    segfmt_pkg::peel_t p;
    logic [31:0]       step;
    logic [31:0]       sub;
    p.digit = '0;
    sub     = '0;
    for (int j = 1; j <= 9; j++) begin
      step = 32'(j) * {8'd0, pow};
      if ({8'd0, rem} >= step) begin
        p.digit = 4'(j);
        sub     = step;
      end
    end
    p.rem = rem - sub[23:0];
    return p;
  endfunction

  function automatic logic [3:0][7:0] show(input logic [3:0][3:0] d,
                                           input logic blank);
    logic [3:0][7:0] b;
    logic            lead;
    lead = blank;
    for (int i = 0; i < 3; i++) begin
      if (lead && d[i] == 4'd0) begin
        b[i] = 8'd0;
      end else begin
        b[i] = segfmt_pkg::glyph(d[i]);
        lead = 1'b0;
      end
    end
    b[3] = segfmt_pkg::glyph(d[3]);
    return b;
  endfunction

  function automatic logic [3:0][7:0] err_image(input logic [23:0] code);
    logic [3:0][7:0] b;
    b[0] = segfmt_pkg::SEG_E;
    b[1] = segfmt_pkg::SEG_R;
    b[2] = segfmt_pkg::SEG_R;
    b[3] = (code <= segfmt_pkg::NIBBLE_MAX) ? segfmt_pkg::glyph(code[3:0]) : 8'd0;
    return b;
  endfunction

  assign adv    = !(vld[NS] && cmd_full);
  assign full   = !adv;
  assign cmd_wr = vld[NS] && !cmd_full;

  always_comb begin
    segfmt_pkg::peel_t p;
    for (int k = 1; k <= NS; k++) begin
      nxt[k] = st[k-1];
      p = peel(st[k-1].rem, segfmt_pkg::POW10[NS-k]);
      nxt[k].dec[NS-k] = p.digit;
      nxt[k].rem       = p.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].req <= request;
      st[0].rem <= request.operand_value;
      st[0].dec <= '0;
      for (int k = 1; k <= NS; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  // command build on the last stage
  always_comb begin
    logic [23:0]     v;
    logic [2:0]      pos;
    logic            pos_ok;
    logic [1:0]      idx;
    logic [3:0][3:0] d;
    logic [6:0][3:0] dec;
    v      = st[NS].req.operand_value;
    pos    = st[NS].req.position;
    dec    = st[NS].dec;
    pos_ok = (pos >= 3'd1) && (pos <= 3'd4);
    idx    = 2'(pos - 3'd1);
    d      = '0;
    cmd.mask   = '0;
    cmd.bytes  = '0;
    cmd.pt_set = 1'b0;
    cmd.pt_clr = 1'b0;
    cmd.idx    = idx;
    cmd.fault  = segfmt_pkg::FAULT_NONE;
    unique case (st[NS].req.action)
      segfmt_pkg::ACT_SET: begin
        if (v > segfmt_pkg::NIBBLE_MAX) begin
          cmd.fault = segfmt_pkg::FAULT_GLYPH;
        end else if (!pos_ok) begin
          cmd.fault = segfmt_pkg::FAULT_POS;
        end else begin
          cmd.mask[idx]  = 1'b1;
          cmd.bytes[idx] = segfmt_pkg::glyph(v[3:0]);
        end
      end
      segfmt_pkg::ACT_BLANK: begin
        if (!pos_ok) begin
          cmd.fault = segfmt_pkg::FAULT_POS;
        end else begin
          cmd.mask[idx] = 1'b1;
        end
      end
      segfmt_pkg::ACT_DEC: begin
        if (v > segfmt_pkg::DEC_MAX) begin
          cmd.fault = segfmt_pkg::FAULT_OVF;
        end else begin
          for (int i = 0; i < 4; i++) begin
            d[i] = dec[3-i];
          end
          cmd.mask  = 4'hF;
          cmd.bytes = show(d, 1'b1);
        end
      end
      segfmt_pkg::ACT_HEX: begin
        if (v > segfmt_pkg::HEX_MAX) begin
          cmd.fault = segfmt_pkg::FAULT_OVF;
        end else begin
          d[0] = v[15:12];
          d[1] = v[11:8];
          d[2] = v[7:4];
          d[3] = v[3:0];
          cmd.mask  = 4'hF;
          cmd.bytes = show(d, 1'b1);
        end
      end
      segfmt_pkg::ACT_BIN: begin
        if (v > segfmt_pkg::NIBBLE_MAX) begin
          cmd.fault = segfmt_pkg::FAULT_OVF;
        end else begin
          for (int i = 0; i < 4; i++) begin
            d[i] = {3'd0, v[3-i]};
          end
          cmd.mask  = 4'hF;
          cmd.bytes = show(d, 1'b0);
        end
      end
      segfmt_pkg::ACT_FIXED: begin
        if (v > segfmt_pkg::FIX_MAX) begin
          cmd.fault = segfmt_pkg::FAULT_OVF;
        end else begin
          cmd.mask = 4'hF;
          if (v >= segfmt_pkg::FIX_INT) begin
            for (int i = 0; i < 4; i++) begin
              d[i] = dec[6-i];
            end
            cmd.bytes = show(d, 1'b1);
          end else if (v >= segfmt_pkg::FIX_TENTHS) begin
            for (int i = 0; i < 4; i++) begin
              d[i] = dec[5-i];
            end
            cmd.bytes       = show(d, 1'b1);
            cmd.bytes[2][7] = 1'b1;
          end else if (v >= segfmt_pkg::FIX_HUNDS) begin
            for (int i = 0; i < 4; i++) begin
              d[i] = dec[4-i];
            end
            cmd.bytes       = show(d, 1'b1);
            cmd.bytes[1][7] = 1'b1;
          end else begin
            for (int i = 0; i < 4; i++) begin
              d[i] = dec[3-i];
            end
            cmd.bytes       = show(d, 1'b0);
            cmd.bytes[0][7] = 1'b1;
          end
        end
      end
      segfmt_pkg::ACT_PT_ON: begin
        if (!pos_ok) begin
          cmd.fault = segfmt_pkg::FAULT_POS;
        end else begin
          cmd.pt_set = 1'b1;
        end
      end
      segfmt_pkg::ACT_PT_OFF: begin
        if (!pos_ok) begin
          cmd.fault = segfmt_pkg::FAULT_POS;
        end else begin
          cmd.pt_clr = 1'b1;
        end
      end
      segfmt_pkg::ACT_ERROR: begin
        cmd.fault = segfmt_pkg::FAULT_REQ;
        cmd.mask  = 4'hF;
        cmd.bytes = err_image(v);
      end
      default: begin
      end
    endcase
    if (cmd.fault == segfmt_pkg::FAULT_GLYPH || cmd.fault == segfmt_pkg::FAULT_POS ||
        cmd.fault == segfmt_pkg::FAULT_OVF) begin
      cmd.mask  = 4'hF;
      cmd.bytes = err_image(24'(cmd.fault));
    end
  end

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (vld[NS] && cmd_full) |=> vld[NS])
    else $error("word at the end of the front dropped while queue full");

  a_fault_full: assert property (@(posedge clk) disable iff (rst)
    (cmd_wr && cmd.fault != segfmt_pkg::FAULT_NONE) |-> (cmd.mask == 4'hF))
    else $error("fault command does not rewrite the whole image");

endmodule

// ----- design/segfmt_back.sv -----
// back part: keeps the display image and applies commands
module segfmt_back (
  input  logic              clk,
  input  logic              rst,
  input  segfmt_pkg::cmd_t  cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              res_push,
  output segfmt_pkg::res_t  res_word,
  input  logic              res_full
);

  logic [3:0][7:0] image;
  logic [3:0][7:0] image_next;
  logic            go;

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  always_comb begin
    image_next = image;
    for (int i = 0; i < 4; i++) begin
      if (cmd.mask[i]) begin
        image_next[i] = cmd.bytes[i];
      end
    end
    if (cmd.pt_set) begin
      image_next[cmd.idx][7] = 1'b1;
    end
    if (cmd.pt_clr) begin
      image_next[cmd.idx][7] = 1'b0;
    end
  end

  assign res_word.digit_one   = image_next[0];
  assign res_word.digit_two   = image_next[1];
  assign res_word.digit_three = image_next[2];
  assign res_word.digit_four  = image_next[3];
  assign res_word.fault       = cmd.fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      image <= '0;
    end else if (go) begin
      image <= image_next;
    end
  end

  a_error_shows_e: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.fault != segfmt_pkg::FAULT_NONE) |=> (image[0] == segfmt_pkg::SEG_E))
    else $error("fault did not leave the error image");

  a_point_alone: assert property (@(posedge clk) disable iff (rst)
    go |-> !(cmd.pt_set && cmd.pt_clr) &&
           !((cmd.pt_set || cmd.pt_clr) && cmd.mask != 4'h0))
    else $error("point command mixed with a digit write");

endmodule

// ----- design/four_digit_segment_display_formatter.sv -----
// top level: four digit seven segment display formatter
// path: a word accepted passes the input register, the peel stages, the command queue and the result queue
// throughput: one word per cycle while the front is not stalled, set by the seven stage decimal digit pipeline
// back pressure on pop holds results in the output queue, then stalls the front
// reset: synchronous, clears the display image and the front's valid bits and empties both queues
module four_digit_segment_display_formatter #(
  parameter int QUEUE_DEPTH = segfmt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  segfmt_pkg::req_t  request,
  output logic              empty,
  input  logic              pop,
  output segfmt_pkg::res_t  result
);

  localparam int CMD_W = $bits(segfmt_pkg::cmd_t);
  localparam int RES_W = $bits(segfmt_pkg::res_t);

  segfmt_pkg::cmd_t cmd_in;
  segfmt_pkg::cmd_t cmd_out;
  segfmt_pkg::res_t res_in;
  logic             cmd_wr;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;

  segfmt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  segfmt_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  segfmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_word  (res_in),
    .res_full  (res_full)
  );

  segfmt_queue #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd      (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
